// ===== hw/rtl/tmlc_pkg.sv =====
// shared types, constants and helpers for the texture mip layout calculator
package tmlc_pkg;

  localparam int unsigned MIP_SLOTS = 11;
  localparam int unsigned ROW_ALIGN = 256;

  localparam int unsigned DIM_W   = 15;
  localparam int unsigned MIP_W   = 4;
  localparam int unsigned SIZE_W  = 33;
  localparam int unsigned ROWB_W  = 19;
  localparam int unsigned PITCH_W = 32;
  localparam int unsigned PROD_W  = PITCH_W + DIM_W;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_PIX1  = 3'd1;
  localparam logic [2:0] CLS_PIX4  = 3'd2;
  localparam logic [2:0] CLS_PIX8  = 3'd3;
  localparam logic [2:0] CLS_PIX16 = 3'd4;
  localparam logic [2:0] CLS_BLK8  = 3'd5;
  localparam logic [2:0] CLS_BLK16 = 3'd6;

  typedef struct packed {
    logic [2:0]       format_class;
    logic [DIM_W-1:0] tex_width;
    logic [DIM_W-1:0] tex_height;
    logic [MIP_W-1:0] lowest_mip;
    logic [MIP_W-1:0] highest_mip;
  } in_t;

  typedef struct packed {
    logic [MIP_W-1:0]  mip_count;
    logic [SIZE_W-1:0] raw_bytes;
    logic [SIZE_W-1:0] padded_bytes;
  } out_t;

  typedef struct packed {
    logic load;
    logic mip_dec;
    logic mul_raw;
    logic mul_pad;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mip_done;
    logic out_free;
  } sts_t;

  // log2 of bytes per unit, and whether the class is supported
  function automatic logic [3:0] unit_shift(input logic [2:0] cls);
    logic [3:0] r;
    case (cls)
      CLS_PIX1:  r = {1'b1, 3'd0};
      CLS_PIX4:  r = {1'b1, 3'd2};
      CLS_PIX8:  r = {1'b1, 3'd3};
      CLS_PIX16: r = {1'b1, 3'd4};
      CLS_BLK8:  r = {1'b1, 3'd3};
      CLS_BLK16: r = {1'b1, 3'd4};
      default:   r = {1'b0, 3'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/tmlc_datapath.sv =====
// datapath: descriptor registers, mip step logic, shared multiplier, result register
module tmlc_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  tmlc_pkg::in_t  in_data,
  input  tmlc_pkg::cmd_t cmd,
  output tmlc_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output tmlc_pkg::out_t out_data
);

  localparam int unsigned DW = tmlc_pkg::DIM_W;
  localparam int unsigned MW = tmlc_pkg::MIP_W;
  localparam int unsigned SW = tmlc_pkg::SIZE_W;
  localparam int unsigned RW = tmlc_pkg::ROWB_W;
  localparam int unsigned PW = tmlc_pkg::PITCH_W;
  localparam int unsigned XW = tmlc_pkg::PROD_W;

  logic          cls_ok_r, block_r, inv_r, out_valid_r;
  logic [DW-1:0] w_r, h_r, rows_r;
  logic [MW-1:0] lo_r, top_r;
  logic [RW-1:0] line_bytes_r;
  logic [PW-1:0] pitch_r;
  logic [SW-1:0] raw_r, pad_r;
  tmlc_pkg::out_t out_data_r;

  logic [3:0]    ush;
  logic          blk_in, inv_in;
  logic [DW:0]   w_sum, h_sum;
  logic [DW-1:0] bw, bh, cols_in, rows_in;
  logic [RW-1:0] line_bytes_in;
  logic [PW-1:0] align_sum, pitch_in;
  logic [MW-1:0] top_in;
  logic [MW-1:0] s;
  logic [DW-1:0] ws, hs, unit;
  logic          dims_ok;
  logic [MW:0]   count5;
  logic [MW-1:0] count;
  logic [PW-1:0] mul_a;
  logic [XW-1:0] prod;
  logic [SW-1:0] prod_sat;

  always_comb begin
    ush    = tmlc_pkg::unit_shift(in_data.format_class);
    blk_in = (in_data.format_class == tmlc_pkg::CLS_BLK8) ||
             (in_data.format_class == tmlc_pkg::CLS_BLK16);
    w_sum  = {1'b0, in_data.tex_width} + (DW+1)'(3);
    h_sum  = {1'b0, in_data.tex_height} + (DW+1)'(3);
    bw     = DW'(w_sum >> 2);
    bh     = DW'(h_sum >> 2);
    if (bw == '0) begin
      bw = DW'(1);
    end
    if (bh == '0) begin
      bh = DW'(1);
    end
    cols_in       = blk_in ? bw : in_data.tex_width;
    rows_in       = blk_in ? bh : in_data.tex_height;
    line_bytes_in = RW'(cols_in) << ush[2:0];
    align_sum     = PW'(line_bytes_in) + PW'(tmlc_pkg::ROW_ALIGN - 1);
    pitch_in      = PW'((align_sum / tmlc_pkg::ROW_ALIGN) * tmlc_pkg::ROW_ALIGN);
    top_in        = (in_data.highest_mip > MW'(tmlc_pkg::MIP_SLOTS - 1)) ?
                    MW'(tmlc_pkg::MIP_SLOTS - 1) : in_data.highest_mip;
    inv_in        = (in_data.tex_width == '0) || (in_data.tex_height == '0) ||
                    (in_data.highest_mip < in_data.lowest_mip) ||
                    (top_in < in_data.lowest_mip);
  end

  // one mip level test per cycle
  always_comb begin
    s        = top_r - lo_r;
    ws       = w_r >> s;
    hs       = h_r >> s;
    unit     = block_r ? DW'(4) : DW'(1);
    dims_ok  = (ws >= unit) && (hs >= unit);
    count5   = {1'b0, top_r} - {1'b0, lo_r} + (MW+1)'(1);
    count    = (count5 > (MW+1)'(15)) ? MW'(15) : count5[MW-1:0];
    if (inv_r) begin
      count = '0;
    end
    sts.mip_done = inv_r || (top_r <= lo_r) || dims_ok;
    sts.out_free = !out_valid_r || out_ready;
  end

  // shared multiplier for raw and padded sizes
  always_comb begin
    mul_a    = cmd.mul_pad ? pitch_r : PW'(line_bytes_r);
    prod     = XW'(mul_a) * XW'(rows_r);
    prod_sat = (prod[XW-1:SW] != '0) ? {SW{1'b1}} : prod[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls_ok_r     <= ush[3];
      block_r      <= blk_in;
      inv_r        <= inv_in;
      w_r          <= in_data.tex_width;
      h_r          <= in_data.tex_height;
      rows_r       <= rows_in;
      lo_r         <= in_data.lowest_mip;
      top_r        <= top_in;
      line_bytes_r <= line_bytes_in;
      pitch_r      <= pitch_in;
    end else if (cmd.mip_dec) begin
      top_r <= top_r - MW'(1);
    end
    if (cmd.mul_raw) begin
      raw_r <= prod_sat;
    end
    if (cmd.mul_pad) begin
      pad_r <= prod_sat;
    end
    if (cmd.out_load) begin
      if (cls_ok_r) begin
        out_data_r.mip_count    <= count;
        out_data_r.raw_bytes    <= raw_r;
        out_data_r.padded_bytes <= pad_r;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/tmlc_ctrl.sv =====
// controller state machine sequencing load, mip steps, multiplies and result hand-off
module tmlc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tmlc_pkg::sts_t sts,
  output tmlc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MIP  = 5'b00010,
    ST_RAW  = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MIP;
        end
      end
      ST_MIP: begin
        if (sts.mip_done) begin
          state_nxt = ST_RAW;
        end else begin
          cmd.mip_dec = 1'b1;
        end
      end
      ST_RAW: begin
        cmd.mul_raw = 1'b1;
        state_nxt   = ST_PAD;
      end
      ST_PAD: begin
        cmd.mul_pad = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/texture_mip_layout_calculator.sv =====
// top level of the texture mip layout calculator
//   channel | ports                         | payload
//   input   | in_valid, in_ready, in_data   | tmlc_pkg::in_t (class, size, mip range)
//   result  | out_valid, out_ready, out_data | tmlc_pkg::out_t (count, raw, padded)
// after the accepting edge the result follows these steps: one mip level tested per cycle
// (1 to MIP_SLOTS levels), the raw and padded sizes on the shared multiplier, and the fill
// of the result register; an idle state then takes the next one.
// reset (rst_n low, synchronous) empties the result register and idles the controller.
// the next transaction is taken while a result waits; it then holds in its final state
// until the result register is free.
module texture_mip_layout_calculator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tmlc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tmlc_pkg::out_t out_data
);

  tmlc_pkg::cmd_t cmd;
  tmlc_pkg::sts_t sts;

  tmlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmlc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_pad_ge_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.padded_bytes >= out_data.raw_bytes)
    else $error("padded size below raw size");

  a_count_has_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mip_count != '0 |-> out_data.raw_bytes != '0)
    else $error("mip count without a size");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.mip_count) <= tmlc_pkg::MIP_SLOTS)
    else $error("mip count above slot count");
`endif

endmodule

// ===== bench/texture_mip_layout_calculator_tb.sv =====
// self-checking testbench for the texture mip layout calculator
module texture_mip_layout_calculator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CLS_UNDEF = 3'd7;
  localparam longint unsigned SIZE_LIMIT = (64'd1 << tmlc_pkg::SIZE_W) - 64'd1;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned HOLD_AFTER = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_t;

  typedef struct {
    tmlc_pkg::in_t  stim;
    bit             typed;
    tmlc_pkg::out_t want;
  } descriptor_case_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  tmlc_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  tmlc_pkg::out_t out_data;

  bit             cur_typed;
  tmlc_pkg::out_t cur_want;

  descriptor_case_t directed_cases[$];
  tmlc_pkg::out_t   layout_q[$];
  int unsigned      mismatch_count;
  int unsigned      descriptors_taken;

  texture_mip_layout_calculator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tmlc_pkg::out_t predict_layout(input tmlc_pkg::in_t d);
    tmlc_pkg::out_t  r;
    longint unsigned unit_bytes;
    longint unsigned cols;
    longint unsigned rows;
    longint unsigned line_bytes;
    longint unsigned pitch;
    longint unsigned raw;
    longint unsigned padded;
    int unsigned     w;
    int unsigned     h;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     top;
    int unsigned     unit_dim;
    int unsigned     shift;
    int unsigned     levels;
    bit              is_block;
    bit              settled;
    w = d.tex_width;
    h = d.tex_height;
    lo = d.lowest_mip;
    hi = d.highest_mip;
    r = '0;
    is_block = (d.format_class == tmlc_pkg::CLS_BLK8) ||
               (d.format_class == tmlc_pkg::CLS_BLK16);
    case (d.format_class)
      tmlc_pkg::CLS_PIX1:  unit_bytes = 1;
      tmlc_pkg::CLS_PIX4:  unit_bytes = 4;
      tmlc_pkg::CLS_PIX8:  unit_bytes = 8;
      tmlc_pkg::CLS_PIX16: unit_bytes = 16;
      tmlc_pkg::CLS_BLK8:  unit_bytes = 8;
      tmlc_pkg::CLS_BLK16: unit_bytes = 16;
      default:             unit_bytes = 0;
    endcase
    if (unit_bytes == 0) return r;
    if (is_block) begin
      cols = (w + 3) / 4;
      rows = (h + 3) / 4;
      if (cols == 0) cols = 1;
      if (rows == 0) rows = 1;
    end else begin
      cols = w;
      rows = h;
    end
    line_bytes = cols * unit_bytes;
    pitch = (line_bytes + tmlc_pkg::ROW_ALIGN - 1) / tmlc_pkg::ROW_ALIGN * tmlc_pkg::ROW_ALIGN;
    raw = line_bytes * rows;
    padded = pitch * rows;
    r.raw_bytes = (raw > SIZE_LIMIT) ? SIZE_LIMIT : raw;
    r.padded_bytes = (padded > SIZE_LIMIT) ? SIZE_LIMIT : padded;
    levels = 0;
    unit_dim = is_block ? 4 : 1;
    if (w != 0 && h != 0 && hi >= lo) begin
      top = (hi > tmlc_pkg::MIP_SLOTS - 1) ? tmlc_pkg::MIP_SLOTS - 1 : hi;
      if (top >= lo) begin
        settled = 1'b0;
        while (top > lo && !settled) begin
          shift = (top - lo) & 15;
          if ((w >> shift) >= unit_dim && (h >> shift) >= unit_dim) settled = 1'b1;
          else top--;
        end
        levels = top - lo + 1;
        if (levels > 15) levels = 15;
      end
    end
    r.mip_count = levels[tmlc_pkg::MIP_W-1:0];
    return r;
  endfunction

  function automatic logic [tmlc_pkg::DIM_W-1:0] random_extent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    else if (pick < 35) return tmlc_pkg::DIM_W'($urandom_range(1, 70));
    else if (pick < 60) return tmlc_pkg::DIM_W'(1 << $urandom_range(0, 14));
    else if (pick < 90) return tmlc_pkg::DIM_W'($urandom_range(0, 16384));
    else return tmlc_pkg::DIM_W'($urandom_range(0, 32767));
  endfunction

  function automatic tmlc_pkg::in_t random_descriptor();
    tmlc_pkg::in_t d;
    int unsigned   pick;
    int unsigned   lo;
    pick = $urandom_range(0, 99);
    if (pick < 4) d.format_class = tmlc_pkg::CLS_NONE;
    else if (pick < 8) d.format_class = CLS_UNDEF;
    else d.format_class = 3'($urandom_range(tmlc_pkg::CLS_PIX1, tmlc_pkg::CLS_BLK16));
    d.tex_width = random_extent();
    d.tex_height = random_extent();
    if ($urandom_range(0, 99) < 15) begin
      d.lowest_mip = tmlc_pkg::MIP_W'($urandom_range(0, 15));
      d.highest_mip = tmlc_pkg::MIP_W'($urandom_range(0, 15));
    end else begin
      lo = $urandom_range(0, 10);
      d.lowest_mip = tmlc_pkg::MIP_W'(lo);
      d.highest_mip = tmlc_pkg::MIP_W'($urandom_range(lo, 15));
    end
    return d;
  endfunction

  task automatic add_case(input logic [2:0] cls, input int unsigned w, input int unsigned h,
                          input int unsigned lo, input int unsigned hi, input bit typed,
                          input int unsigned cnt, input longint unsigned raw,
                          input longint unsigned pad);
    descriptor_case_t c;
    c.stim.format_class = cls;
    c.stim.tex_width = tmlc_pkg::DIM_W'(w);
    c.stim.tex_height = tmlc_pkg::DIM_W'(h);
    c.stim.lowest_mip = tmlc_pkg::MIP_W'(lo);
    c.stim.highest_mip = tmlc_pkg::MIP_W'(hi);
    c.typed = typed;
    c.want.mip_count = tmlc_pkg::MIP_W'(cnt);
    c.want.raw_bytes = tmlc_pkg::SIZE_W'(raw);
    c.want.padded_bytes = tmlc_pkg::SIZE_W'(pad);
    directed_cases.push_back(c);
  endtask

  task automatic report_mismatch(input string what, input logic [69:0] got,
                                 input logic [69:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // input side: record what each accepted descriptor must produce
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      layout_q.push_back(cur_typed ? cur_want : predict_layout(in_data));
      descriptors_taken++;
    end
  end

  // result side: compare against the oldest pending layout
  always @(posedge clk) begin
    tmlc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (layout_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_data, '0);
      end else begin
        want = layout_q.pop_front();
        if (out_data.mip_count !== want.mip_count)
          report_mismatch("mip_count", out_data.mip_count, want.mip_count);
        if (out_data.raw_bytes !== want.raw_bytes)
          report_mismatch("raw_bytes", out_data.raw_bytes, want.raw_bytes);
        if (out_data.padded_bytes !== want.padded_bytes)
          report_mismatch("padded_bytes", out_data.padded_bytes, want.padded_bytes);
      end
    end
  end

  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned span;
    int unsigned phase;
    bit          hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && descriptors_taken >= HOLD_AFTER) begin
        // long back-pressure while the sender keeps offering
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = sink_mode_t'($urandom_range(SINK_OPEN, SINK_SPARSE));
      span = $urandom_range(20, 200);
      phase = 0;
      repeat (span) begin
        @(negedge clk);
        phase++;
        case (mode)
          SINK_OPEN:     out_ready <= 1'b1;
          SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
          SINK_PERIODIC: out_ready <= (phase % 3) != 0;
          default:       out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned idx;
    int unsigned gap;
    int unsigned burst_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    mismatch_count = 0;
    descriptors_taken = 0;

    //       class                width  height lo  hi  typed cnt raw   padded
    add_case(tmlc_pkg::CLS_NONE,  16384, 16384, 0,  10, 1,    0,  0,    0);
    add_case(CLS_UNDEF,           100,   100,   0,  15, 1,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX1,  1,     1,     0,  0,  1,    1,  1,    256);
    add_case(tmlc_pkg::CLS_PIX4,  0,     64,    0,  10, 1,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK8,  0,     0,     0,  5,  1,    0,  8,    256);
    add_case(tmlc_pkg::CLS_PIX1,  64,    64,    5,  3,  1,    0,  4096, 16384);
    add_case(tmlc_pkg::CLS_PIX8,  16,    16,    12, 15, 1,    0,  2048, 4096);
    add_case(tmlc_pkg::CLS_PIX16, 16384, 16384, 0,  15, 1,    11, 64'h1_0000_0000,
             64'h1_0000_0000);
    add_case(tmlc_pkg::CLS_PIX16, 32767, 32767, 0,  15, 1,    11, SIZE_LIMIT, SIZE_LIMIT);
    add_case(tmlc_pkg::CLS_BLK16, 1,     1,     0,  10, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK8,  4,     4,     0,  10, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK8,  5,     7,     0,  10, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK16, 16384, 3,     2,  9,  0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK16, 16384, 16384, 0,  15, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX1,  256,   1,     0,  10, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX4,  1000,  600,   3,  3,  0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX8,  640,   480,   10, 10, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX16, 7,     9,     10, 15, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX4,  16384, 1,     0,  15, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX1,  1,     16384, 4,  15, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_BLK8,  32767, 21845, 1,  12, 0,    0,  0,    0);
    add_case(tmlc_pkg::CLS_PIX8,  21845, 10922, 0,  15, 0,    0,  0,    0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    total = directed_cases.size() + RANDOM_ITEMS;
    burst_left = 0;
    for (idx = 0; idx < total; idx++) begin
      if (idx == directed_cases.size() + RANDOM_ITEMS / 2) begin
        // let the pipeline empty completely
        @(negedge clk);
        in_valid <= 1'b0;
        while (layout_q.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      end
      if (burst_left != 0) burst_left--;
      @(negedge clk);
      if (idx < directed_cases.size()) begin
        in_data <= directed_cases[idx].stim;
        cur_typed <= directed_cases[idx].typed;
        cur_want <= directed_cases[idx].want;
      end else begin
        in_data <= random_descriptor();
        cur_typed <= 1'b0;
      end
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tmlc_pkg.sv
hw/rtl/tmlc_datapath.sv
hw/rtl/tmlc_ctrl.sv
hw/rtl/texture_mip_layout_calculator.sv
bench/texture_mip_layout_calculator_tb.sv
